// ===== src/cgcs_pkg.sv =====
// Package for the capture gamma cascade sampler.
// Holds the branch tables, level tables and shared types; depends on nothing.
package cgcs_pkg;

   // Default draw scale and fixed sizes.
   localparam int DRAW_BITS_DEF = 16;
   localparam int DRAW_W        = 16;
   localparam int NUM_DRAWS     = 5;
   localparam int MAX_BRANCH    = 11;
   localparam int CUM_W         = 17;
   localparam int ENERGY_W      = 17;
   localparam int LEVEL_W       = 4;
   localparam int NUM_W         = 3;
   localparam int IDX_W         = 6;
   localparam int CNT_W         = 4;

   // Isotope select codes.
   localparam logic [1:0] ISO_M40 = 2'd0;
   localparam logic [1:0] ISO_M36 = 2'd1;

   // Ground level of each table.
   localparam logic [LEVEL_W-1:0] GROUND_M40 = 4'd12;
   localparam logic [LEVEL_W-1:0] GROUND_M36 = 4'd13;

   // One branch: cumulative weight through this branch, level reached, energy.
   typedef struct packed {
      logic [CUM_W-1:0]    cum;
      logic [LEVEL_W-1:0]  dest;
      logic [ENERGY_W-1:0] energy;
   } branch_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic mul;
      logic step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic stop;
      logic out_free;
   } status_type;

   // First branch of a level in the flat table.
   function automatic logic [IDX_W-1:0] cgcs_start(logic m36, logic [LEVEL_W-1:0] level);
      logic [IDX_W-1:0] s;
      s = '0;
      if (!m36) begin
         unique case (level)
            4'd1: s = 6'd10;  4'd2: s = 6'd11;  4'd3: s = 6'd13;
            4'd4: s = 6'd16;  4'd5: s = 6'd17;  4'd6: s = 6'd19;
            4'd7: s = 6'd20;  4'd8: s = 6'd23;  4'd9: s = 6'd26;
            4'd10: s = 6'd27; 4'd11: s = 6'd29;
            default: s = 6'd0;
         endcase
      end else begin
         unique case (level)
            4'd1: s = 6'd11;  4'd2: s = 6'd12;  4'd3: s = 6'd13;
            4'd4: s = 6'd15;  4'd5: s = 6'd17;  4'd6: s = 6'd18;
            4'd7: s = 6'd19;  4'd8: s = 6'd20;  4'd9: s = 6'd21;
            4'd10: s = 6'd23; 4'd11: s = 6'd25; 4'd12: s = 6'd26;
            default: s = 6'd0;
         endcase
      end
      return s;
   endfunction

   // Number of branches leaving a level; zero at ground and unused levels.
   function automatic logic [CNT_W-1:0] cgcs_count(logic m36, logic [LEVEL_W-1:0] level);
      logic [CNT_W-1:0] c;
      c = '0;
      if (!m36) begin
         unique case (level)
            4'd0: c = 4'd10;
            4'd1, 4'd4, 4'd6, 4'd9, 4'd11: c = 4'd1;
            4'd2, 4'd5, 4'd10: c = 4'd2;
            4'd3, 4'd7, 4'd8: c = 4'd3;
            default: c = 4'd0;
         endcase
      end else begin
         unique case (level)
            4'd0: c = 4'd11;
            4'd1, 4'd2, 4'd5, 4'd6, 4'd7, 4'd8, 4'd11, 4'd12: c = 4'd1;
            4'd3, 4'd4, 4'd9, 4'd10: c = 4'd2;
            default: c = 4'd0;
         endcase
      end
      return c;
   endfunction

   // Flat branch table, cumulative weights within each level (weights times 1000).
   function automatic branch_type cgcs_branch(logic m36, logic [IDX_W-1:0] idx);
      branch_type b;
      b = '0;
      if (!m36) begin
         unique case (idx)
            6'd0:  b = '{17'd10790, 4'd10, 17'd55820};
            6'd1:  b = '{17'd11032, 4'd9,  17'd50637};
            6'd2:  b = '{17'd62232, 4'd8,  17'd47450};
            6'd3:  b = '{17'd71342, 4'd7,  17'd37004};
            6'd4:  b = '{17'd75252, 4'd6,  17'd33655};
            6'd5:  b = '{17'd78972, 4'd5,  17'd31502};
            6'd6:  b = '{17'd79992, 4'd4,  17'd30894};
            6'd7:  b = '{17'd87992, 4'd3,  17'd27718};
            6'd8:  b = '{17'd92082, 4'd2,  17'd21307};
            6'd9:  b = '{17'd93012, 4'd1,  17'd18288};
            6'd10: b = '{17'd930,   4'd11, 17'd41025};
            6'd11: b = '{17'd1860,  4'd10, 17'd34518};
            6'd12: b = '{17'd4560,  4'd8,  17'd26143};
            6'd13: b = '{17'd5490,  4'd10, 17'd28105};
            6'd14: b = '{17'd5676,  4'd9,  17'd22916};
            6'd15: b = '{17'd6178,  4'd8,  17'd19726};
            6'd16: b = '{17'd818,   4'd11, 17'd28425};
            6'd17: b = '{17'd1580,  4'd11, 17'd27818};
            6'd18: b = '{17'd2361,  4'd10, 17'd24325};
            6'd19: b = '{17'd2600,  4'd11, 17'd25661};
            6'd20: b = '{17'd270,   4'd11, 17'd22295};
            6'd21: b = '{17'd1570,  4'd10, 17'd18815};
            6'd22: b = '{17'd7150,  4'd8,  17'd10443};
            6'd23: b = '{17'd2140,  4'd12, 17'd13540};
            6'd24: b = '{17'd50640, 4'd11, 17'd11868};
            6'd25: b = '{17'd59570, 4'd10, 17'd8377};
            6'd26: b = '{17'd1020,  4'd11, 17'd8673};
            6'd27: b = '{17'd23500, 4'd12, 17'd5160};
            6'd28: b = '{17'd29640, 4'd11, 17'd3487};
            6'd29: b = '{17'd74000, 4'd12, 17'd1673};
            default: b = '0;
         endcase
      end else begin
         unique case (idx)
            6'd0:  b = '{17'd10900,  4'd13, 17'd87904};
            6'd1:  b = '{17'd48400,  4'd10, 17'd62997};
            6'd2:  b = '{17'd73400,  4'd9,  17'd52726};
            6'd3:  b = '{17'd74200,  4'd8,  17'd48518};
            6'd4:  b = '{17'd75800,  4'd7,  17'd48103};
            6'd5:  b = '{17'd79000,  4'd6,  17'd43423};
            6'd6:  b = '{17'd79800,  4'd5,  17'd42116};
            6'd7:  b = '{17'd81600,  4'd4,  17'd41530};
            6'd8:  b = '{17'd95000,  4'd3,  17'd37002};
            6'd9:  b = '{17'd97700,  4'd2,  17'd22076};
            6'd10: b = '{17'd100100, 4'd1,  17'd19667};
            6'd11: b = '{17'd5000,   4'd5,  17'd22479};
            6'd12: b = '{17'd200,    4'd6,  17'd21353};
            6'd13: b = '{17'd7900,   4'd12, 17'd36793};
            6'd14: b = '{17'd11000,  4'd10, 17'd25996};
            6'd15: b = '{17'd1000,   4'd12, 17'd32269};
            6'd16: b = '{17'd1200,   4'd10, 17'd21452};
            6'd17: b = '{17'd300,    4'd10, 17'd20873};
            6'd18: b = '{17'd2000,   4'd10, 17'd19573};
            6'd19: b = '{17'd1300,   4'd13, 17'd39814};
            6'd20: b = '{17'd1000,   4'd13, 17'd39380};
            6'd21: b = '{17'd23700,  4'd12, 17'd21075};
            6'd22: b = '{17'd26400,  4'd10, 17'd10267};
            6'd23: b = '{17'd57000,  4'd13, 17'd24906};
            6'd24: b = '{17'd57500,  4'd11, 17'd8785};
            6'd25: b = '{17'd3400,   4'd13, 17'd16117};
            6'd26: b = '{17'd33000,  4'd13, 17'd14103};
            default: b = '0;
         endcase
      end
      return b;
   endfunction

endpackage

// ===== src/cgcs_ctrl.sv =====
// Controller state machine of the capture gamma cascade sampler.
// Depends on cgcs_pkg for the command and status types.
module cgcs_ctrl
   import cgcs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MUL  = 3'b010,
      ST_SEL  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (status.stop) begin
               state_in = ST_IDLE;
            end else begin
               cmd.mul  = 1'b1;
               state_in = ST_SEL;
            end
         end
         ST_SEL: begin
            if (status.out_free) begin
               cmd.step = 1'b1;
               state_in = ST_MUL;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/cgcs_datapath.sv =====
// Datapath of the capture gamma cascade sampler: draws, level walk, branch
// compare and the result register. Depends on cgcs_pkg.
module cgcs_datapath
   import cgcs_pkg::*;
#(
   parameter int DRAW_BITS = DRAW_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   output status_type                  status,
   input  logic [1:0]                  req_tuser,
   input  logic [NUM_DRAWS*DRAW_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [23:0]                 rsp_tdata,
   output logic                        rsp_tlast
);

   localparam int PROD_W = DRAW_W + CUM_W;
   localparam int RHS_W  = CUM_W + DRAW_BITS;
   localparam int CMP_W  = (PROD_W > RHS_W) ? PROD_W : RHS_W;

   logic [DRAW_W-1:0]  draw_ff [NUM_DRAWS];
   logic               valid_iso_ff;
   logic               m36_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic               out_valid_ff;
   logic [ENERGY_W-1:0] out_energy_ff;
   logic [LEVEL_W-1:0] out_level_ff;
   logic [NUM_W-1:0]   out_num_ff;
   logic               out_last_ff;

   logic [IDX_W-1:0]   start;
   logic [CNT_W-1:0]   count;
   logic [LEVEL_W-1:0] ground;
   branch_type         last_br;
   logic [CMP_W-1:0]   lhs;
   logic [MAX_BRANCH-1:0] hit;
   branch_type         lane_br [MAX_BRANCH];
   branch_type         pick_br;
   logic               out_free;

   // Level lookups.
   assign start   = cgcs_start(m36_ff, level_ff);
   assign count   = cgcs_count(m36_ff, level_ff);
   assign ground  = m36_ff ? GROUND_M36 : GROUND_M40;
   assign last_br = cgcs_branch(m36_ff, start + IDX_W'(count) - IDX_W'(1));

   // Stop when the isotope has no table, at ground, at a dead level or after five gammas.
   assign status.stop = !valid_iso_ff || (level_ff == ground) || (count == '0)
                        || (num_ff == NUM_W'(NUM_DRAWS));
   assign out_free        = !out_valid_ff || rsp_tready;
   assign status.out_free = out_free;

   // Parallel cumulative compares, one lane per branch.
   assign lhs = CMP_W'(prod_ff);
   always_comb begin
      for (int k = 0; k < MAX_BRANCH; k++) begin
         lane_br[k] = cgcs_branch(m36_ff, start + IDX_W'(k));
         hit[k]     = (CNT_W'(k) < count) &&
                      (lhs <= CMP_W'({lane_br[k].cum, {DRAW_BITS{1'b0}}}));
      end
   end

   // First hit wins; with no hit the last branch of the level is taken.
   always_comb begin
      pick_br = last_br;
      for (int k = MAX_BRANCH - 1; k >= 0; k--) begin
         if (hit[k]) begin
            pick_br = lane_br[k];
         end
      end
   end

   // Event registers and the walk.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_iso_ff <= 1'b0;
         level_ff     <= '0;
         num_ff       <= '0;
      end else if (cmd.load) begin
         valid_iso_ff <= (req_tuser == ISO_M40) || (req_tuser == ISO_M36);
         level_ff     <= '0;
         num_ff       <= '0;
      end else if (cmd.step) begin
         level_ff <= pick_br.dest;
         num_ff   <= num_ff + NUM_W'(1);
      end
   end

   // Payload registers: draws, table select and the product.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         m36_ff <= (req_tuser == ISO_M36);
         for (int i = 0; i < NUM_DRAWS; i++) begin
            draw_ff[i] <= req_tdata[i*DRAW_W +: DRAW_W];
         end
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(draw_ff[num_ff]) * PROD_W'(last_br.cum);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.step) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         out_energy_ff <= pick_br.energy;
         out_level_ff  <= pick_br.dest;
         out_num_ff    <= num_ff;
         out_last_ff   <= (pick_br.dest == ground);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_num_ff, out_level_ff, out_energy_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== src/capture_gamma_cascade_sampler_unit.sv =====
// Top level of the capture gamma cascade sampler.
// Joins cgcs_ctrl and cgcs_datapath; depends on cgcs_pkg.
//
// One request beat is one capture event; it yields zero to five response beats,
// one per gamma of the cascade, tlast on the gamma that reaches ground. Each
// gamma is a product of draw and level total, then the parallel branch compare,
// all through the one shared multiplier and compare stage; a new gamma also
// waits for the previous response beat to be taken. A new event is taken once
// the previous walk is done, even while its last response still waits.
module capture_gamma_cascade_sampler_unit
   import cgcs_pkg::*;
#(
   parameter int DRAW_BITS = DRAW_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // draw_first, draw_second, draw_third, draw_fourth, draw_fifth
   input  logic [1:0]  req_tuser,   // isotope
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // gamma_energy, level_reached, gamma_number
   output logic        rsp_tlast    // last_gamma
);

   cmd_type    cmd;
   status_type status;

   cgcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cgcs_datapath #(
      .DRAW_BITS (DRAW_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== src/cgcs_checker.sv =====
// Port-level checker for the capture gamma cascade sampler and its bind.
// Depends on the top level's port list only.
module cgcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled response beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response beat changed");

   // Gamma position stays within five.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:21] <= 3'd4)
      else $error("gamma number out of range");

   // The last gamma lands on a ground level.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[20:17] == 4'd12 || rsp_tdata[20:17] == 4'd13)
      else $error("last gamma not at ground");

   // Every emitted gamma carries energy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[16:0] != 17'd0)
      else $error("zero gamma energy");

endmodule

bind capture_gamma_cascade_sampler_unit cgcs_checker u_cgcs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
